FILE: src/jsev_pkg.sv
`timescale 1ns / 1ps

package jsev_pkg;

  localparam int AXIS_COUNT  = 6;
  localparam int AXIS_W      = 3;
  localparam int BUTTON_MAX  = 32;
  localparam int AXIS_CENTRE = 32768;
  localparam int HAT_DIRS    = 4;
  localparam int U_AXIS      = 4;
  localparam int U_FIX       = 100;

  localparam int RAW_W  = 16;
  localparam int IN_W   = 32 + (AXIS_COUNT + 1) * RAW_W;
  localparam int OUT_W  = 40;
  localparam int USER_W = 4;

  localparam logic [15:0] THR_RESET = 16'd9830;

  localparam logic [2:0] CFG_BUTTON_COUNT   = 3'd0;
  localparam logic [2:0] CFG_AXIS_ENABLE    = 3'd1;
  localparam logic [2:0] CFG_HAT_PRESENT    = 3'd2;
  localparam logic [2:0] CFG_HAT_DIAGONALS  = 3'd3;
  localparam logic [2:0] CFG_U_AXIS_FIX     = 3'd4;
  localparam logic [2:0] CFG_AXIS_THRESHOLD = 3'd5;

  localparam logic [15:0] HAT_ANGLE  [HAT_DIRS] = '{16'd0, 16'd9000, 16'd18000, 16'd27000};
  localparam logic [15:0] DIAG_ANGLE [HAT_DIRS] = '{16'd4500, 16'd13500, 16'd22500, 16'd31500};
  localparam logic [3:0]  DIAG_BITS  [HAT_DIRS] = '{4'h3, 4'h6, 4'hC, 4'h9};

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_ANALOG  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SRC_BUTTON   = 2'd0,
    SRC_AXIS_BTN = 2'd1,
    SRC_HAT      = 2'd2,
    SRC_ANALOG   = 2'd3
  } source_t;

  typedef logic signed [16:0] axval_t;

  typedef struct packed {
    logic [5:0]  button_count;
    logic [5:0]  axis_enable;
    logic        hat_present;
    logic        hat_diagonals;
    logic        u_axis_fix;
    logic [15:0] axis_threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0]                  buttons;
    axval_t [AXIS_COUNT-1:0]      vals;
    logic [HAT_DIRS-1:0]          hat_dirs;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    source_t            source;
    logic [4:0]         index;
    logic signed [16:0] value;
    logic signed [17:0] delta;
  } event_t;

endpackage

FILE: src/jsev_front.sv
`timescale 1ns / 1ps

module jsev_front (
  input  jsev_pkg::cfg_t                  cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [jsev_pkg::IN_W-1:0]       in_tdata,
  input  logic                            q_full,
  output logic                            q_push,
  output jsev_pkg::entry_t                q_data
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // centre the axes and decode the hat ahead of the sequencer
  always_comb begin
    logic [15:0] raw;
    logic [17:0] ext;
    logic [15:0] angle;
    q_data.buttons = in_tdata[31:0];
    for (int j = 0; j < jsev_pkg::AXIS_COUNT; j++) begin
      raw = in_tdata[32 + jsev_pkg::RAW_W * j +: jsev_pkg::RAW_W];
      ext = {2'b00, raw}
          + (((j == jsev_pkg::U_AXIS) && cfg.u_axis_fix) ? 18'(jsev_pkg::U_FIX) : 18'd0)
          - 18'(jsev_pkg::AXIS_CENTRE);
      q_data.vals[j] = ext[16:0];
    end
    angle = in_tdata[32 + jsev_pkg::RAW_W * jsev_pkg::AXIS_COUNT +: jsev_pkg::RAW_W];
    q_data.hat_dirs = '0;
    for (int j = 0; j < jsev_pkg::HAT_DIRS; j++) begin
      if (angle == jsev_pkg::HAT_ANGLE[j]) q_data.hat_dirs[j] = 1'b1;
      if (cfg.hat_diagonals && (angle == jsev_pkg::DIAG_ANGLE[j])) begin
        q_data.hat_dirs = q_data.hat_dirs | jsev_pkg::DIAG_BITS[j];
      end
    end
  end

endmodule

FILE: src/jsev_queue.sv
`timescale 1ns / 1ps

module jsev_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsev_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output jsev_pkg::entry_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsev_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");

endmodule

FILE: src/jsev_back.sv
`timescale 1ns / 1ps

module jsev_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  jsev_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  input  jsev_pkg::entry_t               q_data,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [jsev_pkg::OUT_W-1:0]     out_tdata,
  output logic [jsev_pkg::USER_W-1:0]    out_tuser,
  output logic                           out_tlast
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ANALOG = 6'b000010,
    ST_BUTTON = 6'b000100,
    ST_THRESH = 6'b001000,
    ST_HAT    = 6'b010000,
    ST_FLUSH  = 6'b100000
  } state_t;

  state_t                        phase_r, phase_nxt;
  logic [4:0]                    idx_r, idx_nxt;
  jsev_pkg::axval_t              prev_vals_r [jsev_pkg::AXIS_COUNT];
  logic [31:0]                   prev_btn_r;
  logic [2*jsev_pkg::AXIS_COUNT-1:0] prev_axb_r;
  logic [jsev_pkg::HAT_DIRS-1:0] prev_hat_r;
  logic                          hold_valid_r;
  jsev_pkg::event_t              hold_r;
  logic                          out_valid_r;
  jsev_pkg::event_t              out_r;
  logic                          out_last_r;

  logic [jsev_pkg::AXIS_W-1:0]   ax_sel;
  logic                          ax_ok, ax_on;
  jsev_pkg::axval_t              cur_val, prev_val;
  logic signed [17:0]            delta, val_x, thr_x;
  logic                          cond;
  logic [5:0]                    btn_lim;
  logic                          ev_hit, last_slot;
  jsev_pkg::event_t              ev;
  logic                          scanning, out_free, stall, step, flush_go, out_load;

  always_comb begin
    ax_sel   = (phase_r == ST_THRESH) ? idx_r[3:1] : idx_r[2:0];
    ax_ok    = (ax_sel < jsev_pkg::AXIS_W'(jsev_pkg::AXIS_COUNT));
    ax_on    = ax_ok && cfg.axis_enable[ax_sel];
    cur_val  = ax_ok ? q_data.vals[ax_sel] : '0;
    prev_val = ax_ok ? prev_vals_r[ax_sel] : '0;
    delta    = $signed({cur_val[16], cur_val}) - $signed({prev_val[16], prev_val});
    val_x    = $signed({prev_val[16], prev_val});
    thr_x    = $signed({2'b00, cfg.axis_threshold});
    cond     = idx_r[0] ? (val_x < -thr_x) : (val_x > thr_x);
    btn_lim  = (cfg.button_count > 6'(jsev_pkg::BUTTON_MAX)) ?
               6'(jsev_pkg::BUTTON_MAX) : cfg.button_count;
  end

  always_comb begin
    ev        = '0;
    ev_hit    = 1'b0;
    last_slot = 1'b0;
    unique case (phase_r)
      ST_ANALOG: begin
        ev_hit    = ax_on && (delta != '0);
        ev.kind   = jsev_pkg::KIND_ANALOG;
        ev.source = jsev_pkg::SRC_ANALOG;
        ev.index  = 5'(ax_sel);
        ev.value  = cur_val;
        ev.delta  = delta;
        last_slot = (idx_r == 5'(jsev_pkg::AXIS_COUNT - 1));
      end
      ST_BUTTON: begin
        ev_hit    = (q_data.buttons[idx_r] ^ prev_btn_r[idx_r]) && ({1'b0, idx_r} < btn_lim);
        ev.kind   = q_data.buttons[idx_r] ? jsev_pkg::KIND_PRESS : jsev_pkg::KIND_RELEASE;
        ev.source = jsev_pkg::SRC_BUTTON;
        ev.index  = idx_r;
        last_slot = (idx_r == 5'(jsev_pkg::BUTTON_MAX - 1));
      end
      ST_THRESH: begin
        ev_hit    = ax_on && (cond != prev_axb_r[idx_r[3:0]]);
        ev.kind   = cond ? jsev_pkg::KIND_PRESS : jsev_pkg::KIND_RELEASE;
        ev.source = jsev_pkg::SRC_AXIS_BTN;
        ev.index  = idx_r;
        last_slot = (idx_r == 5'(2 * jsev_pkg::AXIS_COUNT - 1));
      end
      ST_HAT: begin
        ev_hit    = cfg.hat_present &&
                    (q_data.hat_dirs[idx_r[1:0]] != prev_hat_r[idx_r[1:0]]);
        ev.kind   = q_data.hat_dirs[idx_r[1:0]] ? jsev_pkg::KIND_PRESS
                                                : jsev_pkg::KIND_RELEASE;
        ev.source = jsev_pkg::SRC_HAT;
        ev.index  = idx_r;
        last_slot = (idx_r == 5'(jsev_pkg::HAT_DIRS - 1));
      end
      default: begin
        ev_hit = 1'b0;
      end
    endcase
  end

  // one event is held back so the final one can carry tlast
  assign scanning = (phase_r == ST_ANALOG) || (phase_r == ST_BUTTON) ||
                    (phase_r == ST_THRESH) || (phase_r == ST_HAT);
  assign out_free = !out_valid_r || out_tready;
  assign stall    = ev_hit && hold_valid_r && !out_free;
  assign step     = scanning && !stall;
  assign flush_go = (phase_r == ST_FLUSH) && (!hold_valid_r || out_free);
  assign out_load = hold_valid_r && ((step && ev_hit) || flush_go);
  assign q_pop    = flush_go;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (step) begin
      idx_nxt = last_slot ? '0 : idx_r + 5'd1;
    end
    unique case (phase_r)
      ST_IDLE: begin
        if (q_valid) begin
          phase_nxt = ST_ANALOG;
          idx_nxt   = '0;
        end
      end
      ST_ANALOG: if (step && last_slot) phase_nxt = ST_BUTTON;
      ST_BUTTON: if (step && last_slot) phase_nxt = ST_THRESH;
      ST_THRESH: if (step && last_slot) phase_nxt = ST_HAT;
      ST_HAT:    if (step && last_slot) phase_nxt = ST_FLUSH;
      ST_FLUSH:  if (flush_go) phase_nxt = ST_IDLE;
      default:   phase_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ST_IDLE;
      idx_r        <= '0;
      prev_btn_r   <= '0;
      prev_axb_r   <= '0;
      prev_hat_r   <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int j = 0; j < jsev_pkg::AXIS_COUNT; j++) begin
        prev_vals_r[j] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      if (step) begin
        if ((phase_r == ST_ANALOG) && ax_on) prev_vals_r[ax_sel] <= cur_val;
        if ((phase_r == ST_BUTTON) && last_slot) prev_btn_r <= q_data.buttons;
        if ((phase_r == ST_THRESH) && ev_hit) prev_axb_r[idx_r[3:0]] <= cond;
        if ((phase_r == ST_HAT) && last_slot && cfg.hat_present) begin
          prev_hat_r <= q_data.hat_dirs;
        end
      end
      if (step && ev_hit) begin
        hold_valid_r <= 1'b1;
      end else if (flush_go) begin
        hold_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && ev_hit) begin
      hold_r <= ev;
    end
    if (out_load) begin
      out_r      <= hold_r;
      out_last_r <= flush_go;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.delta, out_r.value, out_r.index};
  assign out_tuser  = {out_r.source, out_r.kind};
  assign out_tlast  = out_last_r;

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ST_IDLE) |-> !hold_valid_r)
    else $error("held word left over after sample");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output word overwritten before taken");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("sample retired from empty queue");

endmodule

FILE: src/joystick_poll_event_generator_core.sv
`timescale 1ns / 1ps

// Joystick poll event generator. Each input word is one poll sample; the block
// emits one output word per event: analog changes of enabled axes, then button
// press/release for buttons below button_count, then axis half-button threshold
// crossings, then hat direction changes. tlast marks the last event of a sample;
// a sample with no events gives no output. The event sequencer steps through
// the 54 event slots in order between a start state and a closing flush state,
// and it can stall while the output is back-pressured. A queue of QUEUE_DEPTH
// samples in front of the sequencer accepts new samples meanwhile.
// Configuration must only be written while the block is idle.

module joystick_poll_event_generator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_addr,
  input  logic [15:0]                    cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // button_bits, x_raw, y_raw, z_raw, r_raw, u_raw, v_raw, hat_angle
  input  logic [jsev_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // event_index, analog_value, analog_delta
  output logic [jsev_pkg::OUT_W-1:0]     out_tdata,
  // event_kind, event_source
  output logic [jsev_pkg::USER_W-1:0]    out_tuser,
  output logic                           out_tlast
);

  jsev_pkg::cfg_t   cfg_r;
  logic             q_full, q_push, q_valid, q_pop;
  jsev_pkg::entry_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_count   <= '0;
      cfg_r.axis_enable    <= '0;
      cfg_r.hat_present    <= 1'b0;
      cfg_r.hat_diagonals  <= 1'b0;
      cfg_r.u_axis_fix     <= 1'b0;
      cfg_r.axis_threshold <= jsev_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        jsev_pkg::CFG_BUTTON_COUNT:   cfg_r.button_count   <= cfg_wdata[5:0];
        jsev_pkg::CFG_AXIS_ENABLE:    cfg_r.axis_enable    <= cfg_wdata[5:0];
        jsev_pkg::CFG_HAT_PRESENT:    cfg_r.hat_present    <= cfg_wdata[0];
        jsev_pkg::CFG_HAT_DIAGONALS:  cfg_r.hat_diagonals  <= cfg_wdata[0];
        jsev_pkg::CFG_U_AXIS_FIX:     cfg_r.u_axis_fix     <= cfg_wdata[0];
        jsev_pkg::CFG_AXIS_THRESHOLD: cfg_r.axis_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  jsev_front u_front (
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  jsev_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  jsev_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
